>>> src/tpd_pkg.sv
// Package for the tile package deframer: result layout, codes and framing constants.
// No dependencies; the result queue and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

  // Framing constants
  localparam logic [4:0]  MIN_SEEN    = 5'd20;          // smallest legal package, bytes
  localparam logic [3:0]  FIELD_LAST  = 4'd3;           // last byte of a 4-byte field
  localparam logic [3:0]  ID_BYTES    = 4'd4;           // header bytes holding the id
  localparam logic [3:0]  LEN_FIRST   = 4'd8;           // first header byte of the size
  localparam logic [3:0]  HDR_LAST    = 4'd11;          // last byte of a 12-byte header
  localparam logic [31:0] MAGIC_RESET = 32'h2E2E2E2E;

  // Result queue geometry (depth must be a power of two, at least 2)
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_SMALL = 3'd1,
    STAT_BAD_MAGIC = 3'd2,
    STAT_TRUNC_HDR = 3'd3,
    STAT_TRUNC_DAT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tile_number;
    logic [31:0] tile_ident;
    logic [31:0] tile_length;
    logic [7:0]  data_byte;
    logic        tile_end;
    logic [2:0]  status;
    logic        result_last;
  } result_t;

  // Up to two results enter the queue per accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    lead;
    result_t    trail;
  } push_t;

endpackage

`default_nettype wire

>>> src/tpd_if.sv
// Channel interfaces of the tile package deframer: byte input and result output.
// Depends on nothing; field names follow the block's item layout.
`timescale 1ns / 1ps
`default_nettype none

interface tpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;

  modport source (output valid, output byte_in, output end_of_file, input ready);
  modport sink   (input valid, input byte_in, input end_of_file, output ready);
endinterface

interface tpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] tile_number;
  logic [31:0] tile_ident;
  logic [31:0] tile_length;
  logic [7:0]  data_byte;
  logic        tile_end;
  logic [2:0]  status;
  logic        result_last;

  modport source (output valid, output kind, output tile_number, output tile_ident,
                  output tile_length, output data_byte, output tile_end,
                  output status, output result_last, input ready);
  modport sink   (input valid, input kind, input tile_number, input tile_ident,
                  input tile_length, input data_byte, input tile_end,
                  input status, input result_last, output ready);
endinterface

`default_nettype wire

>>> src/tpd_result_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
// Depends on tpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpd_result_fifo
  import tpd_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire push_t push,
  output logic    room,
  output logic    out_valid,
  output result_t out_data,
  input  wire     out_ready
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     level;
  logic                 pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (level != '0);
  assign out_data  = mem[rd_ptr];
  // keep space for the worst case of two results from one byte
  assign room      = (level <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.lead;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.trail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      level  <= level + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/tile_package_deframer_unit.sv
// Tile package deframer, top level. A result is written into the result queue when its byte
// is accepted and offered from the queue head. Throughput: one byte per cycle; an end-of-file
// byte that closes a header or data byte yields two results, which drain in order through a
// four-entry result queue, and input stalls only while fewer than two queue slots are free.
// Reset (rst, synchronous, active high) clears the parser and the queue and loads the
// magic register with 0x2E2E2E2E; no clearing pass, the block takes bytes right after.
`timescale 1ns / 1ps
`default_nettype none

module tile_package_deframer_unit
  import tpd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  tpd_byte_if.sink     bytes,
  tpd_result_if.source results,
  input  wire          cfg_we,
  input  wire [31:0]   cfg_wdata
);

  // Parser phases
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_COUNT,
    PH_HEADER,
    PH_DATA,
    PH_DONE,
    PH_FAILED
  } phase_t;

  // Configuration
  logic [31:0] magic_word;

  // Parser state
  phase_t      phase, phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [4:0]  total_seen, total_seen_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [31:0] tiles_expected, tiles_expected_next;
  logic [31:0] tiles_finished, tiles_finished_next;
  logic [31:0] current_ident, current_ident_next;
  logic [31:0] current_length, current_length_next;
  logic [31:0] bytes_left, bytes_left_next;

  // Byte-merge helpers
  logic [31:0] magic_cat;
  logic [31:0] count_cat;
  logic [31:0] ident_cat;
  logic [31:0] length_cat;
  logic [31:0] finished_inc;
  logic        all_done;

  // Result assembly
  logic        accept;
  logic        prim_valid;
  result_t     prim;
  result_t     stat_res;
  status_t     stat_code;
  push_t       push;
  result_t     head;
  logic        room;

  assign accept = bytes.valid & bytes.ready;

  // Magic arrives little-endian: first byte in bits 7:0
  assign magic_cat  = magic_shift | (32'(bytes.byte_in) << {field_byte_count[1:0], 3'b000});
  // Count, id and size are big-endian: shift in at the bottom
  assign count_cat  = {tiles_expected[23:0], bytes.byte_in};
  assign ident_cat  = {current_ident[23:0], bytes.byte_in};
  assign length_cat = {current_length[23:0], bytes.byte_in};
  assign finished_inc = tiles_finished + 32'd1;
  assign all_done     = (finished_inc == tiles_expected);

  // Next-state and primary result (header or data) for the byte on the input
  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    magic_shift_next      = magic_shift;
    tiles_expected_next   = tiles_expected;
    tiles_finished_next   = tiles_finished;
    current_ident_next    = current_ident;
    current_length_next   = current_length;
    bytes_left_next       = bytes_left;
    prim_valid            = 1'b0;
    prim                  = '0;

    // saturate the byte count once the package is big enough
    total_seen_next = (total_seen < MIN_SEEN) ? total_seen + 5'd1 : total_seen;

    case (phase)
      PH_MAGIC: begin
        magic_shift_next      = magic_cat;
        field_byte_count_next = field_byte_count + 4'd1;
        if (field_byte_count == FIELD_LAST) begin
          field_byte_count_next = '0;
          phase_next = (magic_cat != magic_word) ? PH_FAILED : PH_COUNT;
        end
      end
      PH_COUNT: begin
        tiles_expected_next   = count_cat;
        field_byte_count_next = field_byte_count + 4'd1;
        if (field_byte_count == FIELD_LAST) begin
          field_byte_count_next = '0;
          tiles_finished_next   = '0;
          // a count of zero finishes the package at once
          phase_next = (count_cat == '0) ? PH_DONE : PH_HEADER;
        end
      end
      PH_HEADER: begin
        // id bytes, then four padding bytes dropped, then size bytes
        if (field_byte_count < ID_BYTES) begin
          current_ident_next = ident_cat;
        end else if (field_byte_count >= LEN_FIRST) begin
          current_length_next = length_cat;
        end
        field_byte_count_next = field_byte_count + 4'd1;
        if (field_byte_count == HDR_LAST) begin
          field_byte_count_next = '0;
          prim_valid       = 1'b1;
          prim.kind        = KIND_HEADER;
          prim.tile_number = tiles_finished;
          prim.tile_ident  = current_ident;
          prim.tile_length = length_cat;
          if (length_cat == '0) begin
            // empty tile: header only, finish it now
            tiles_finished_next = finished_inc;
            phase_next = all_done ? PH_DONE : PH_HEADER;
          end else begin
            bytes_left_next = length_cat;
            phase_next      = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        prim_valid       = 1'b1;
        prim.kind        = KIND_DATA;
        prim.tile_number = tiles_finished;
        prim.tile_ident  = current_ident;
        prim.tile_length = current_length;
        prim.data_byte   = bytes.byte_in;
        prim.tile_end    = (bytes_left == 32'd1);
        bytes_left_next  = bytes_left - 32'd1;
        if (bytes_left == 32'd1) begin
          tiles_finished_next   = finished_inc;
          field_byte_count_next = '0;
          phase_next = all_done ? PH_DONE : PH_HEADER;
        end
      end
      default: begin
        // done or failed: drop trailing bytes until end of file
      end
    endcase

    // the primary result is last unless a status follows
    prim.result_last = ~bytes.end_of_file;
  end

  // Final status, judged on the state this byte leaves behind
  always_comb begin
    if (total_seen_next < MIN_SEEN) begin
      stat_code = STAT_TOO_SMALL;
    end else if (phase_next == PH_FAILED) begin
      stat_code = STAT_BAD_MAGIC;
    end else if (phase_next == PH_DONE) begin
      stat_code = STAT_OK;
    end else if (phase_next == PH_DATA) begin
      stat_code = STAT_TRUNC_DAT;
    end else begin
      stat_code = STAT_TRUNC_HDR;
    end

    stat_res             = '0;
    stat_res.kind        = KIND_STATUS;
    stat_res.status      = stat_code;
    stat_res.tile_number = (stat_code == STAT_OK) ? tiles_expected_next : '0;
    stat_res.result_last = 1'b1;
  end

  // Queue write: primary first, then status on the final byte
  always_comb begin
    push       = '0;
    push.lead  = prim_valid ? prim : stat_res;
    push.trail = stat_res;
    if (accept) begin
      push.count = 2'(prim_valid) + 2'(bytes.end_of_file);
    end
  end

  // Parser registers: advance on each accepted byte, clear after the status
  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.end_of_file)) begin
      phase            <= PH_MAGIC;
      field_byte_count <= '0;
      total_seen       <= '0;
      magic_shift      <= '0;
      tiles_expected   <= '0;
      tiles_finished   <= '0;
      current_ident    <= '0;
      current_length   <= '0;
      bytes_left       <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      total_seen       <= total_seen_next;
      magic_shift      <= magic_shift_next;
      tiles_expected   <= tiles_expected_next;
      tiles_finished   <= tiles_finished_next;
      current_ident    <= current_ident_next;
      current_length   <= current_length_next;
      bytes_left       <= bytes_left_next;
    end
  end

  // Magic register: the user writes it only while idle (not enforced here); survives end of package
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= MAGIC_RESET;
    end else if (cfg_we) begin
      magic_word <= cfg_wdata;
    end
  end

  // Result queue decouples the two sides
  tpd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (results.valid),
    .out_data  (head),
    .out_ready (results.ready)
  );

  assign bytes.ready         = room;
  assign results.kind        = head.kind;
  assign results.tile_number = head.tile_number;
  assign results.tile_ident  = head.tile_ident;
  assign results.tile_length = head.tile_length;
  assign results.data_byte   = head.data_byte;
  assign results.tile_end    = head.tile_end;
  assign results.status      = head.status;
  assign results.result_last = head.result_last;

  // Checks

  // End of file returns the parser to its idle start
  a_eof_clears : assert property (@(posedge clk) disable iff (rst)
    accept && bytes.end_of_file |=>
      phase == PH_MAGIC && field_byte_count == '0 && total_seen == '0)
    else $error("parser not cleared after end of file");

  // Data phase always has bytes outstanding
  a_data_left : assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with no bytes left");

  // Input only stalls behind queued results
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> results.valid)
    else $error("input stalled with an empty result queue");

endmodule

`default_nettype wire
